// ===== hw/rtl/oled_init_and_page_writer_defines.svh =====
// ----------------------------------------------------------------------------
// OLED init and page writer assertion macros
// Concurrent checks, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef OLED_INIT_AND_PAGE_WRITER_DEFINES_SVH
`define OLED_INIT_AND_PAGE_WRITER_DEFINES_SVH

`ifndef ASSERT_OFF
`define OLEDPW_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define OLEDPW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define OLEDPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define OLEDPW_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define OLEDPW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OLEDPW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/oledpw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OLED init and page writer package
// Control word format, microcode program and register indexes.
// ----------------------------------------------------------------------------
package oledpw_pkg;

    localparam int PC_W = 5;
    localparam int INIT_LEN = 25;
    localparam int CONTRAST_SLOT = 17;

    localparam logic [PC_W-1:0] PC_INIT = 5'd0;
    localparam logic [PC_W-1:0] PC_PAGE = 5'd25;
    localparam logic [PC_W-1:0] PC_DATA = 5'd28;

    localparam logic CFG_CONTRAST = 1'b0;
    localparam logic CFG_COLUMN   = 1'b1;

    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    localparam logic [0:INIT_LEN-1][7:0] INIT_SEQ = {
        8'hAE, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40, 8'h8D, 8'h14,
        8'h20, 8'h00, 8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'hCF, 8'hD9, 8'hF1,
        8'hDB, 8'h40, 8'hA4, 8'hA6, 8'hAF
    };

    typedef enum logic [2:0] {
        SRC_LIT,
        SRC_CONTRAST,
        SRC_PAGE,
        SRC_COLUMN,
        SRC_PIXEL
    } src_t;

    typedef struct packed {
        src_t       src;
        logic [7:0] lit;
        logic       is_data;
        logic       last;
        logic       pos_clear;
        logic       pos_step;
    } ctrl_word_t;

    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{src: SRC_LIT, lit: 8'h00, is_data: 1'b0, last: 1'b1,
              pos_clear: 1'b0, pos_step: 1'b0};
        unique case (pc) inside
            [5'd0:5'd24]:
            begin
                w.lit       = INIT_SEQ[pc];
                w.src       = (pc == PC_W'(CONTRAST_SLOT)) ? SRC_CONTRAST : SRC_LIT;
                w.last      = (pc == PC_W'(INIT_LEN - 1));
                w.pos_clear = (pc == PC_W'(INIT_LEN - 1));
            end
            5'd25:
            begin
                w.src  = SRC_PAGE;
                w.last = 1'b0;
            end
            5'd26:
            begin
                w.src  = SRC_COLUMN;
                w.last = 1'b0;
            end
            5'd27:
            begin
                w.lit  = CMD_COL_HIGH;
                w.last = 1'b0;
            end
            5'd28:
            begin
                w.src      = SRC_PIXEL;
                w.is_data  = 1'b1;
                w.pos_step = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/oled_init_and_page_writer.sv =====
// Bytes go out one per cycle after a transfer in, unless the link holds off.
// An init item issues 25 bytes, a pixel item one byte, or four at a page start.
// The next item is taken in the cycle the last byte of the current one is issued.
// The output register stalls the program while the link holds off.
// Reset: contrast 207, column start 1, frame position zero, no transfer pending.
`timescale 1ns / 1ps
`include "oled_init_and_page_writer_defines.svh"
// ----------------------------------------------------------------------------
// OLED init and page writer
// Microcoded sequencer that turns init requests and frame bytes into
// command and data bytes for a page-addressed OLED controller.
// ----------------------------------------------------------------------------
module oled_init_and_page_writer
    import oledpw_pkg::*;
#(
    parameter int PAGES   = 8,
    parameter int COLUMNS = 128
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] pixel_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] link_byte,
    output logic       is_data,
    output logic       last
);

    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(COLUMNS - 1);
    localparam logic [PAGE_W-1:0] PAGE_MAX = PAGE_W'(PAGES - 1);

    logic [7:0]        contrast_reg;
    logic [3:0]        column_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic              busy_reg, busy_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [7:0]        pix_reg;
    logic              out_valid_reg;
    logic [7:0]        link_byte_reg;
    logic              is_data_reg;
    logic              last_reg;

    ctrl_word_t        word;
    logic              issue;
    logic              accept;
    logic [7:0]        issue_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contrast_reg <= 8'd207;
            column_reg   <= 4'd1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_CONTRAST: contrast_reg <= cfg_wdata;
                CFG_COLUMN:   column_reg   <= cfg_wdata[3:0];
                default:      contrast_reg <= contrast_reg;
            endcase
        end
    end

    assign word     = ucode(pc_reg);
    assign issue    = busy_reg && (!out_valid_reg || out_ready);
    assign in_ready = !busy_reg || (issue && word.last);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        case (word.src)
            SRC_CONTRAST: issue_byte = contrast_reg;
            SRC_PAGE:     issue_byte = CMD_PAGE_BASE + 8'(page_reg);
            SRC_COLUMN:   issue_byte = {4'h0, column_reg};
            SRC_PIXEL:    issue_byte = pix_reg;
            default:      issue_byte = word.lit;
        endcase
    end

    always_comb
    begin
        col_next  = col_reg;
        page_next = page_reg;
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (issue && word.pos_clear)
        begin
            col_next  = '0;
            page_next = '0;
        end
        else if (issue && word.pos_step)
        begin
            if (col_reg == COL_MAX)
            begin
                col_next  = '0;
                page_next = (page_reg == PAGE_MAX) ? '0 : page_reg + PAGE_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
        if (issue)
        begin
            if (word.last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pc_next = pc_reg + PC_W'(1);
            end
        end
        if (accept)
        begin
            busy_next = 1'b1;
            if (!op)
            begin
                pc_next = PC_INIT;
            end
            else
            begin
                pc_next = (col_next == '0) ? PC_PAGE : PC_DATA;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            page_reg      <= '0;
            busy_reg      <= 1'b0;
            pc_reg        <= PC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            page_reg <= page_next;
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= pixel_byte;
        end
        if (issue)
        begin
            link_byte_reg <= issue_byte;
            is_data_reg   <= word.is_data;
            last_reg      <= word.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign link_byte = link_byte_reg;
    assign is_data   = is_data_reg;
    assign last      = last_reg;

    `OLEDPW_ASSERT_ALWAYS(a_pos_range, clk, rst_n, (col_reg <= COL_MAX) && (page_reg <= PAGE_MAX))
    `OLEDPW_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_reg)
    `OLEDPW_ASSERT_IMP(a_data_ends, clk, rst_n, issue && word.is_data, word.last)
    `OLEDPW_ASSERT_IMP(a_idle_no_issue, clk, rst_n, !busy_reg, !issue)

endmodule

// ===== tb/sv/tb_oled_init_and_page_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// OLED init and page writer testbench
// Feeds init requests and frame bytes through the valid/ready input with
// bursty gaps, stalls the link side on a pattern of its own, and checks
// every link byte against a local prediction of the power-up sequence,
// the page and column commands and the frame position across a page
// boundary. The contrast and column registers are rewritten between
// phases, extremes included.
// ----------------------------------------------------------------------------
module tb_oled_init_and_page_writer;
    import oledpw_pkg::*;

    localparam int PAGES        = 8;
    localparam int COLUMNS      = 128;
    localparam int FRAME_BYTES  = PAGES * COLUMNS;
    localparam int POWER_UP_LEN = 25;
    localparam int CONTRAST_POS = 17;

    localparam logic OP_INIT  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] pix;
    } frame_item_t;

    typedef struct packed {
        logic [7:0] link_byte;
        logic       is_data;
        logic       last;
    } link_out_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic       cfg_index;
    logic [7:0] cfg_wdata;
    logic       in_valid;
    logic       in_ready;
    logic       op;
    logic [7:0] pixel_byte;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] link_byte;
    logic       is_data;
    logic       last;

    frame_item_t items_to_send[$];
    link_out_t   link_bytes_due[$];

    logic [9:0]  frame_pos;
    logic [7:0]  contrast_reg;
    logic [3:0]  column_reg;

    int          error_count;
    bit          item_taken;
    bit          gaps_on;
    bit          stalls_on;
    int          gap_left;
    int          burst_left;
    int          window_left;
    int          hold_left;
    frame_item_t next_item;
    link_out_t   want;

    oled_init_and_page_writer #(
        .PAGES   (PAGES),
        .COLUMNS (COLUMNS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .pixel_byte (pixel_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .link_byte  (link_byte),
        .is_data    (is_data),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] power_up_byte(input int idx);
        case (idx)
            0:  return 8'hAE;
            1:  return 8'hD5;
            2:  return 8'h80;
            3:  return 8'hA8;
            4:  return 8'h3F;
            5:  return 8'hD3;
            6:  return 8'h00;
            7:  return 8'h40;
            8:  return 8'h8D;
            9:  return 8'h14;
            10: return 8'h20;
            11: return 8'h00;
            12: return 8'hA1;
            13: return 8'hC8;
            14: return 8'hDA;
            15: return 8'h12;
            16: return 8'h81;
            17: return 8'hCF;
            18: return 8'hD9;
            19: return 8'hF1;
            20: return 8'hDB;
            21: return 8'h40;
            22: return 8'hA4;
            23: return 8'hA6;
            default: return 8'hAF;
        endcase
    endfunction

    task automatic predict_link_bytes(input logic item_op, input logic [7:0] item_pix);
        link_out_t r;
        if (item_op == OP_INIT)
        begin
            for (int i = 0; i < POWER_UP_LEN; i++)
            begin
                r.link_byte = (i == CONTRAST_POS) ? contrast_reg : power_up_byte(i);
                r.is_data   = 1'b0;
                r.last      = (i == POWER_UP_LEN - 1);
                link_bytes_due.push_back(r);
            end
            frame_pos = '0;
        end
        else
        begin
            if (int'(frame_pos) % COLUMNS == 0)
            begin
                r = '{link_byte: CMD_PAGE_BASE + 8'(int'(frame_pos) / COLUMNS),
                      is_data: 1'b0, last: 1'b0};
                link_bytes_due.push_back(r);
                r = '{link_byte: {4'h0, column_reg}, is_data: 1'b0, last: 1'b0};
                link_bytes_due.push_back(r);
                r = '{link_byte: CMD_COL_HIGH, is_data: 1'b0, last: 1'b0};
                link_bytes_due.push_back(r);
            end
            r = '{link_byte: item_pix, is_data: 1'b1, last: 1'b1};
            link_bytes_due.push_back(r);
            // wrap at the end of the frame
            if (int'(frame_pos) + 1 >= FRAME_BYTES)
                frame_pos = '0;
            else
                frame_pos = frame_pos + 10'd1;
        end
    endtask

    // check each link transfer, then predict for each input transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (link_bytes_due.size() == 0)
                begin
                    $display("%0t: unexpected link byte %02h is_data %0b last %0b",
                             $time, link_byte, is_data, last);
                    error_count++;
                end
                else
                begin
                    want = link_bytes_due.pop_front();
                    if (link_byte !== want.link_byte)
                    begin
                        $display("%0t: link_byte expected %02h actual %02h",
                                 $time, want.link_byte, link_byte);
                        error_count++;
                    end
                    if (is_data !== want.is_data)
                    begin
                        $display("%0t: is_data expected %0b actual %0b",
                                 $time, want.is_data, is_data);
                        error_count++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, last);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predict_link_bytes(op, pixel_byte);
                item_taken = 1'b1;
            end
        end
    end

    // sender: bursts of transfers with random gaps between them
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || item_taken))
        begin
            item_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (items_to_send.size() > 0)
            begin
                next_item = items_to_send.pop_front();
                in_valid   <= 1'b1;
                op         <= next_item.op;
                pixel_byte <= next_item.pix;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left   = gaps_on ? $urandom_range(1, 6) : 0;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: hold off at the start of windows of random length
    always @(negedge clk)
    begin
        if (window_left == 0)
        begin
            window_left = $urandom_range(2, 10);
            hold_left   = $urandom_range(0, 4);
        end
        window_left--;
        if (stalls_on && hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic queue_item(input logic item_op, input logic [7:0] item_pix);
        frame_item_t it;
        it.op  = item_op;
        it.pix = item_pix;
        items_to_send.push_back(it);
    endtask

    task automatic queue_random_traffic(input int n_items);
        int added;
        int run;
        added = 0;
        queue_item(OP_INIT, 8'($urandom));
        while (added < n_items)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                queue_item(OP_INIT, 8'($urandom));
                added++;
            end
            else
            begin
                run = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 140)
                                                  : $urandom_range(1, 20);
                if (run > n_items - added)
                    run = n_items - added;
                repeat (run)
                begin
                    case ($urandom_range(0, 7))
                        0:       queue_item(OP_PIXEL, 8'h00);
                        1:       queue_item(OP_PIXEL, 8'hFF);
                        default: queue_item(OP_PIXEL, 8'($urandom));
                    endcase
                    added++;
                end
            end
        end
    endtask

    task automatic wait_until_drained();
        while (items_to_send.size() > 0 || in_valid || link_bytes_due.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input logic index, input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_CONTRAST)
            contrast_reg = value;
        else
            column_reg = value[3:0];
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_CONTRAST;
        cfg_wdata    = 8'h00;
        in_valid     = 1'b0;
        op           = OP_INIT;
        pixel_byte   = 8'h00;
        out_ready    = 1'b0;
        frame_pos    = '0;
        contrast_reg = 8'd207;
        column_reg   = 4'd1;
        error_count  = 0;
        item_taken   = 1'b0;
        gaps_on      = 1'b0;
        stalls_on    = 1'b0;
        gap_left     = 0;
        burst_left   = 0;
        window_left  = 0;
        hold_left    = 0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset register values, no idling
        queue_item(OP_PIXEL, 8'h00);
        queue_item(OP_PIXEL, 8'hFF);
        queue_item(OP_INIT,  8'hFF);
        queue_item(OP_PIXEL, 8'hA5);
        queue_item(OP_PIXEL, 8'h5A);
        queue_item(OP_PIXEL, 8'h01);
        queue_item(OP_PIXEL, 8'h80);
        queue_item(OP_INIT,  8'h3C);
        queue_item(OP_PIXEL, 8'hFF);
        queue_item(OP_INIT,  8'h00);
        queue_item(OP_INIT,  8'hC3);
        queue_item(OP_PIXEL, 8'h00);
        wait_until_drained();

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        write_register(CFG_CONTRAST, 8'h00);
        write_register(CFG_COLUMN,   8'h0F);
        queue_item(OP_INIT,  8'h00);
        queue_item(OP_PIXEL, 8'h7E);
        queue_random_traffic(35);
        wait_until_drained();

        write_register(CFG_CONTRAST, 8'hFF);
        write_register(CFG_COLUMN,   8'h00);
        queue_random_traffic(35);
        wait_until_drained();

        // run across a page boundary
        gaps_on = 1'b0;
        write_register(CFG_CONTRAST, 8'($urandom));
        write_register(CFG_COLUMN,   8'($urandom_range(0, 15)));
        queue_item(OP_INIT, 8'($urandom));
        repeat (COLUMNS + 8) queue_item(OP_PIXEL, 8'($urandom));
        wait_until_drained();

        gaps_on   = 1'b1;
        stalls_on = 1'b0;
        write_register(CFG_COLUMN,   8'($urandom_range(0, 15)));
        write_register(CFG_CONTRAST, 8'($urandom));
        queue_random_traffic(20);
        wait_until_drained();

        stalls_on = 1'b1;
        write_register(CFG_CONTRAST, 8'($urandom));
        write_register(CFG_COLUMN,   8'($urandom_range(0, 15)));
        queue_random_traffic(20);
        wait_until_drained();

        repeat (40) @(negedge clk);
        if (error_count == 0)
            $display("tb_oled_init_and_page_writer: done, clean");
        else
            $display("tb_oled_init_and_page_writer: done, errors");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout, %0d link bytes still due", $time, link_bytes_due.size());
        $display("tb_oled_init_and_page_writer: done, errors");
        $finish;
    end

endmodule
